### hdl/dllc_pkg.sv
package dllc_pkg;

  // pool size and field widths
  localparam int NODES_DEFAULT = 256;
  localparam int CMD_W         = 5;
  localparam int DATA_W        = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_DISPOSE       = 5'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT_FIRST  = 5'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT_LAST   = 5'd2;
  localparam logic [CMD_W-1:0] CMD_CURSOR_FIRST  = 5'd3;
  localparam logic [CMD_W-1:0] CMD_CURSOR_LAST   = 5'd4;
  localparam logic [CMD_W-1:0] CMD_GET_FIRST     = 5'd5;
  localparam logic [CMD_W-1:0] CMD_GET_LAST      = 5'd6;
  localparam logic [CMD_W-1:0] CMD_DELETE_FIRST  = 5'd7;
  localparam logic [CMD_W-1:0] CMD_DELETE_LAST   = 5'd8;
  localparam logic [CMD_W-1:0] CMD_DELETE_AFTER  = 5'd9;
  localparam logic [CMD_W-1:0] CMD_DELETE_BEFORE = 5'd10;
  localparam logic [CMD_W-1:0] CMD_INSERT_AFTER  = 5'd11;
  localparam logic [CMD_W-1:0] CMD_INSERT_BEFORE = 5'd12;
  localparam logic [CMD_W-1:0] CMD_GET_CURSOR    = 5'd13;
  localparam logic [CMD_W-1:0] CMD_SET_CURSOR    = 5'd14;
  localparam logic [CMD_W-1:0] CMD_CURSOR_NEXT   = 5'd15;
  localparam logic [CMD_W-1:0] CMD_CURSOR_PREV   = 5'd16;

  // command sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WR1,
    S_WR2
  } state_t;

endpackage

### hdl/dllc_ram.sv
module dllc_ram import dllc_pkg::*; #(
  parameter int DEPTH = NODES_DEFAULT,
  parameter int WIDTH = DATA_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/doubly_linked_list_cursor_engine_unit.sv
// Doubly linked list of signed 32-bit values with a cursor, held in a pool of
// NODES nodes. A command is taken when start is high and busy is low; its
// result appears on read_value, error, cursor_valid and list_empty for exactly
// one cycle with done high, once the command has passed states RD1, RD2, WR1
// and WR2; busy stays high until then, and the next command may be given in
// that same cycle. The sequence is set by the link memories: each has one
// write port and one registered read port, and a command needs two dependent
// reads (a neighbour, then its neighbour) and up to two writes into the same
// link memory. There is no clearing pass after reset; the block is ready in the
// first cycle after rst falls. Results cannot be held off by the receiver.
module doubly_linked_list_cursor_engine_unit import dllc_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] value_in,
  output logic                     done,
  output logic signed [DATA_W-1:0] read_value,
  output logic                     error,
  output logic                     cursor_valid,
  output logic                     list_empty
);

  localparam int PW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam logic [PW-1:0] NIL = PW'(NODES);

  state_t state, state_next;

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] val_q;
  logic [PW-1:0]     head_ptr, tail_ptr, cursor_ptr, free_head, fresh_count;
  logic [PW-1:0]     n1, p1, n2, p2;
  logic [DATA_W-1:0] v1;

  // memory ports
  logic              value_we, next_we, prev_we;
  logic [AW-1:0]     value_waddr, next_waddr, prev_waddr;
  logic [AW-1:0]     value_raddr, next_raddr, prev_raddr;
  logic [DATA_W-1:0] value_wdata, value_rdata;
  logic [PW-1:0]     next_wdata, prev_wdata, next_rdata, prev_rdata;

  // plan of one command
  logic [PW-1:0]     head_next, tail_next, cursor_next, free_next, fresh_next;
  logic [DATA_W-1:0] rd_res;
  logic              err_res;
  logic              vwe, nwe1, nwe2, pwe1, pwe2;
  logic [PW-1:0]     vaddr, na1, nd1, na2, nd2, pa1, pd1, pa2, pd2;
  logic [PW-1:0]     n2_cur, p2_cur;

  // node allocation
  logic              free_nz, pool_full;
  logic [PW-1:0]     new_node, take_free, take_fresh;

  dllc_ram #(.DEPTH(NODES), .WIDTH(DATA_W)) u_value (
    .clk   (clk),
    .we    (value_we),
    .waddr (value_waddr),
    .wdata (value_wdata),
    .raddr (value_raddr),
    .rdata (value_rdata)
  );

  dllc_ram #(.DEPTH(NODES), .WIDTH(PW)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  dllc_ram #(.DEPTH(NODES), .WIDTH(PW)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  assign busy = (state != S_IDLE);

  // free list first, then never-used nodes in index order
  assign free_nz    = (free_head != NIL);
  assign pool_full  = !free_nz && (fresh_count == NIL);
  assign new_node   = free_nz ? free_head : fresh_count;
  assign take_free  = free_nz ? n1 : free_head;
  assign take_fresh = free_nz ? fresh_count : fresh_count + PW'(1);

  // second read arrives during the first write cycle
  assign n2_cur = (state == S_WR1) ? next_rdata : n2;
  assign p2_cur = (state == S_WR1) ? prev_rdata : p2;

  // read addresses: first and second dependent read
  always_comb begin
    value_raddr = cursor_ptr[AW-1:0];
    next_raddr  = cursor_ptr[AW-1:0];
    prev_raddr  = cursor_ptr[AW-1:0];
    if (state == S_RD2) begin
      if (cmd_q == CMD_DELETE_AFTER) begin
        next_raddr = next_rdata[AW-1:0];
      end
      if (cmd_q == CMD_DELETE_BEFORE) begin
        prev_raddr = prev_rdata[AW-1:0];
      end
    end else begin
      case (cmd_q) inside
        CMD_INSERT_FIRST, CMD_INSERT_LAST, CMD_INSERT_AFTER, CMD_INSERT_BEFORE:
          next_raddr = free_head[AW-1:0];
        CMD_DELETE_FIRST: next_raddr = head_ptr[AW-1:0];
        default: next_raddr = cursor_ptr[AW-1:0];
      endcase
      if (cmd_q == CMD_DELETE_LAST) begin
        prev_raddr = tail_ptr[AW-1:0];
      end
      if (cmd_q == CMD_GET_FIRST) begin
        value_raddr = head_ptr[AW-1:0];
      end else if (cmd_q == CMD_GET_LAST) begin
        value_raddr = tail_ptr[AW-1:0];
      end
    end
  end

  // command plan: pointer updates, result and link writes
  always_comb begin
    head_next   = head_ptr;
    tail_next   = tail_ptr;
    cursor_next = cursor_ptr;
    free_next   = free_head;
    fresh_next  = fresh_count;
    rd_res      = '0;
    err_res     = 1'b0;
    vwe  = 1'b0; vaddr = cursor_ptr;
    nwe1 = 1'b0; na1 = NIL; nd1 = NIL;
    nwe2 = 1'b0; na2 = NIL; nd2 = NIL;
    pwe1 = 1'b0; pa1 = NIL; pd1 = NIL;
    pwe2 = 1'b0; pa2 = NIL; pd2 = NIL;
    unique case (cmd_q) inside
      CMD_DISPOSE: begin
        if (head_ptr != NIL) begin
          nwe1 = 1'b1; na1 = tail_ptr; nd1 = free_head;
          free_next   = head_ptr;
          head_next   = NIL;
          tail_next   = NIL;
          cursor_next = NIL;
        end
      end
      CMD_INSERT_FIRST: begin
        if (pool_full) begin
          err_res = 1'b1;
        end else begin
          free_next = take_free; fresh_next = take_fresh;
          vwe  = 1'b1; vaddr = new_node;
          nwe1 = 1'b1; na1 = new_node; nd1 = head_ptr;
          pwe1 = 1'b1; pa1 = new_node; pd1 = NIL;
          if (head_ptr != NIL) begin
            pwe2 = 1'b1; pa2 = head_ptr; pd2 = new_node;
          end else begin
            tail_next = new_node;
          end
          head_next = new_node;
        end
      end
      CMD_INSERT_LAST: begin
        if (pool_full) begin
          err_res = 1'b1;
        end else begin
          free_next = take_free; fresh_next = take_fresh;
          vwe  = 1'b1; vaddr = new_node;
          pwe1 = 1'b1; pa1 = new_node; pd1 = tail_ptr;
          nwe1 = 1'b1; na1 = new_node; nd1 = NIL;
          if (tail_ptr != NIL) begin
            nwe2 = 1'b1; na2 = tail_ptr; nd2 = new_node;
          end else begin
            head_next = new_node;
          end
          tail_next = new_node;
        end
      end
      CMD_CURSOR_FIRST: cursor_next = head_ptr;
      CMD_CURSOR_LAST:  cursor_next = tail_ptr;
      CMD_GET_FIRST: begin
        if (head_ptr == NIL) err_res = 1'b1;
        else rd_res = v1;
      end
      CMD_GET_LAST: begin
        if (tail_ptr == NIL) err_res = 1'b1;
        else rd_res = v1;
      end
      CMD_DELETE_FIRST: begin
        if (head_ptr != NIL) begin
          if (cursor_ptr == head_ptr) cursor_next = NIL;
          if (head_ptr == tail_ptr) begin
            head_next = NIL;
            tail_next = NIL;
          end else begin
            head_next = n1;
            pwe1 = 1'b1; pa1 = n1; pd1 = NIL;
          end
          nwe1 = 1'b1; na1 = head_ptr; nd1 = free_head;
          free_next = head_ptr;
        end
      end
      CMD_DELETE_LAST: begin
        if (tail_ptr != NIL) begin
          if (cursor_ptr == tail_ptr) cursor_next = NIL;
          if (head_ptr == tail_ptr) begin
            head_next = NIL;
            tail_next = NIL;
          end else begin
            tail_next = p1;
            nwe2 = 1'b1; na2 = p1; nd2 = NIL;
          end
          nwe1 = 1'b1; na1 = tail_ptr; nd1 = free_head;
          free_next = tail_ptr;
        end
      end
      CMD_DELETE_AFTER: begin
        // n1 is the victim, n2_cur the node after it
        if (cursor_ptr != NIL && cursor_ptr != tail_ptr) begin
          nwe1 = 1'b1; na1 = cursor_ptr; nd1 = n2_cur;
          if (n1 == tail_ptr) begin
            tail_next = cursor_ptr;
          end else begin
            pwe1 = 1'b1; pa1 = n2_cur; pd1 = cursor_ptr;
          end
          nwe2 = 1'b1; na2 = n1; nd2 = free_head;
          free_next = n1;
        end
      end
      CMD_DELETE_BEFORE: begin
        // p1 is the victim, p2_cur the node before it
        if (cursor_ptr != NIL && cursor_ptr != head_ptr) begin
          pwe1 = 1'b1; pa1 = cursor_ptr; pd1 = p2_cur;
          if (p1 == head_ptr) begin
            head_next = cursor_ptr;
          end else begin
            nwe1 = 1'b1; na1 = p2_cur; nd1 = cursor_ptr;
          end
          nwe2 = 1'b1; na2 = p1; nd2 = free_head;
          free_next = p1;
        end
      end
      CMD_INSERT_AFTER: begin
        // n2_cur is the old successor of the cursor
        if (cursor_ptr != NIL) begin
          if (pool_full) begin
            err_res = 1'b1;
          end else begin
            free_next = take_free; fresh_next = take_fresh;
            vwe  = 1'b1; vaddr = new_node;
            nwe1 = 1'b1; na1 = new_node; nd1 = n2_cur;
            pwe1 = 1'b1; pa1 = new_node; pd1 = cursor_ptr;
            nwe2 = 1'b1; na2 = cursor_ptr; nd2 = new_node;
            if (cursor_ptr == tail_ptr) begin
              tail_next = new_node;
            end else begin
              pwe2 = 1'b1; pa2 = n2_cur; pd2 = new_node;
            end
          end
        end
      end
      CMD_INSERT_BEFORE: begin
        // p1 is the old predecessor of the cursor
        if (cursor_ptr != NIL) begin
          if (pool_full) begin
            err_res = 1'b1;
          end else begin
            free_next = take_free; fresh_next = take_fresh;
            vwe  = 1'b1; vaddr = new_node;
            pwe1 = 1'b1; pa1 = new_node; pd1 = p1;
            nwe1 = 1'b1; na1 = new_node; nd1 = cursor_ptr;
            pwe2 = 1'b1; pa2 = cursor_ptr; pd2 = new_node;
            if (cursor_ptr == head_ptr) begin
              head_next = new_node;
            end else begin
              nwe2 = 1'b1; na2 = p1; nd2 = new_node;
            end
          end
        end
      end
      CMD_GET_CURSOR: begin
        if (cursor_ptr == NIL) err_res = 1'b1;
        else rd_res = v1;
      end
      CMD_SET_CURSOR: begin
        if (cursor_ptr != NIL) begin
          vwe = 1'b1; vaddr = cursor_ptr;
        end
      end
      CMD_CURSOR_NEXT: begin
        if (cursor_ptr != NIL) cursor_next = (cursor_ptr == tail_ptr) ? NIL : n1;
      end
      CMD_CURSOR_PREV: begin
        if (cursor_ptr != NIL) cursor_next = (cursor_ptr == head_ptr) ? NIL : p1;
      end
      default: begin
      end
    endcase
  end

  // write ports: first slot in WR1, second slot in WR2
  always_comb begin
    value_we    = (state == S_WR1) && vwe;
    value_waddr = vaddr[AW-1:0];
    value_wdata = val_q;
    if (state == S_WR2) begin
      next_we    = nwe2;
      next_waddr = na2[AW-1:0];
      next_wdata = nd2;
      prev_we    = pwe2;
      prev_waddr = pa2[AW-1:0];
      prev_wdata = pd2;
    end else begin
      next_we    = (state == S_WR1) && nwe1;
      next_waddr = na1[AW-1:0];
      next_wdata = nd1;
      prev_we    = (state == S_WR1) && pwe1;
      prev_waddr = pa1[AW-1:0];
      prev_wdata = pd1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_RD1;
      S_RD1:  state_next = S_RD2;
      S_RD2:  state_next = S_WR1;
      S_WR1:  state_next = S_WR2;
      S_WR2:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // command beat and read captures
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q <= cmd;
      val_q <= value_in;
    end
    if (state == S_RD2) begin
      n1 <= next_rdata;
      p1 <= prev_rdata;
      v1 <= value_rdata;
    end
    if (state == S_WR1) begin
      n2 <= next_rdata;
      p2 <= prev_rdata;
    end
  end

  // list pointers and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr    <= NIL;
      tail_ptr    <= NIL;
      cursor_ptr  <= NIL;
      free_head   <= NIL;
      fresh_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= (state == S_WR2);
      if (state == S_WR2) begin
        head_ptr    <= head_next;
        tail_ptr    <= tail_next;
        cursor_ptr  <= cursor_next;
        free_head   <= free_next;
        fresh_count <= fresh_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WR2) begin
      read_value   <= rd_res;
      error        <= err_res;
      cursor_valid <= (cursor_next != NIL);
      list_empty   <= (head_next == NIL);
    end
  end

  // head and tail are null together
  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    (head_ptr == NIL) == (tail_ptr == NIL))
    else $error("head and tail disagree on an empty list");

  // an active element implies a non-empty list
  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    (cursor_ptr != NIL) |-> (head_ptr != NIL))
    else $error("cursor set on an empty list");

  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    (done && list_empty) |-> !cursor_valid)
    else $error("result shows a cursor on an empty list");

  // fresh count never runs past the pool
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_count <= NIL)
    else $error("fresh count beyond pool size");

  // an accepted beat goes through RD1, RD2 and WR1 into write-back in WR2
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##3 (state == S_WR2))
    else $error("command did not reach write-back in time");

endmodule

### bench/testbench.sv
module testbench;
  import dllc_pkg::*;

  localparam int NODES = NODES_DEFAULT;
  localparam int IDX_W = $clog2(NODES) + 1;
  localparam logic [IDX_W-1:0] NIL = IDX_W'(NODES);
  localparam logic [CMD_W-1:0] CMD_TOP = {CMD_W{1'b1}};

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [CMD_W-1:0]         op;
    logic signed [DATA_W-1:0] read_value;
    logic                     error;
    logic                     cursor_valid;
    logic                     list_empty;
  } outcome_t;

  typedef enum int unsigned {TR_GROW, TR_SHRINK, TR_MIXED} traffic_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         cmd = '0;
  logic signed [DATA_W-1:0] value_in = '0;
  logic                     done;
  logic signed [DATA_W-1:0] read_value;
  logic                     error;
  logic                     cursor_valid;
  logic                     list_empty;

  // list mirror; entry NIL of each pool array is never touched
  logic signed [DATA_W-1:0] pool_value [NODES+1];
  idx_t                     pool_next [NODES+1];
  idx_t                     pool_prev [NODES+1];
  idx_t                     head_idx = NIL;
  idx_t                     tail_idx = NIL;
  idx_t                     cursor_idx = NIL;
  idx_t                     free_idx = NIL;
  idx_t                     fresh_used = '0;
  int                       list_len = 0;

  outcome_t                 pending_outcomes [$];
  int                       mismatch_count = 0;
  bit                       gaps_on = 1'b1;

  doubly_linked_list_cursor_engine_unit #(
    .NODES(NODES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .value_in(value_in),
    .done(done),
    .read_value(read_value),
    .error(error),
    .cursor_valid(cursor_valid),
    .list_empty(list_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pool allocation: free list first, then untouched nodes in index order
  function automatic idx_t take_node();
    idx_t n;
    n = NIL;
    if (free_idx != NIL) begin
      n = free_idx;
      free_idx = pool_next[n];
    end else if (fresh_used < NODES) begin
      n = fresh_used;
      fresh_used = fresh_used + 1'b1;
    end
    return n;
  endfunction

  function automatic void give_node(input idx_t n);
    pool_next[n] = free_idx;
    free_idx = n;
    list_len--;
  endfunction

  // apply one command to the mirror and return the beat it should produce
  function automatic outcome_t list_step_outcome(input logic [CMD_W-1:0] c,
                                                 input logic signed [DATA_W-1:0] v);
    outcome_t r;
    idx_t     cur;
    idx_t     n;
    idx_t     d;
    r = '0;
    r.op = c;
    cur = cursor_idx;
    case (c)
      CMD_DISPOSE: begin
        if (head_idx != NIL) begin
          pool_next[tail_idx] = free_idx;
          free_idx = head_idx;
          head_idx = NIL;
          tail_idx = NIL;
          cursor_idx = NIL;
          list_len = 0;
        end
      end
      CMD_INSERT_FIRST, CMD_INSERT_LAST: begin
        n = take_node();
        if (n == NIL) begin
          r.error = 1'b1;
        end else begin
          pool_value[n] = v;
          list_len++;
          if (c == CMD_INSERT_FIRST) begin
            pool_next[n] = head_idx;
            pool_prev[n] = NIL;
            if (head_idx != NIL) pool_prev[head_idx] = n;
            else tail_idx = n;
            head_idx = n;
          end else begin
            pool_prev[n] = tail_idx;
            pool_next[n] = NIL;
            if (tail_idx != NIL) pool_next[tail_idx] = n;
            else head_idx = n;
            tail_idx = n;
          end
        end
      end
      CMD_CURSOR_FIRST: cursor_idx = head_idx;
      CMD_CURSOR_LAST: cursor_idx = tail_idx;
      CMD_GET_FIRST, CMD_GET_LAST: begin
        n = (c == CMD_GET_FIRST) ? head_idx : tail_idx;
        if (n == NIL) r.error = 1'b1;
        else r.read_value = pool_value[n];
      end
      CMD_DELETE_FIRST, CMD_DELETE_LAST: begin
        d = (c == CMD_DELETE_FIRST) ? head_idx : tail_idx;
        if (d != NIL) begin
          if (cur == d) cursor_idx = NIL;
          if (head_idx == tail_idx) begin
            head_idx = NIL;
            tail_idx = NIL;
          end else if (c == CMD_DELETE_FIRST) begin
            head_idx = pool_next[d];
            pool_prev[head_idx] = NIL;
          end else begin
            tail_idx = pool_prev[d];
            pool_next[tail_idx] = NIL;
          end
          give_node(d);
        end
      end
      CMD_DELETE_AFTER: begin
        if (cur != NIL && cur != tail_idx) begin
          d = pool_next[cur];
          pool_next[cur] = pool_next[d];
          if (d == tail_idx) tail_idx = cur;
          else pool_prev[pool_next[d]] = cur;
          give_node(d);
        end
      end
      CMD_DELETE_BEFORE: begin
        if (cur != NIL && cur != head_idx) begin
          d = pool_prev[cur];
          pool_prev[cur] = pool_prev[d];
          if (d == head_idx) head_idx = cur;
          else pool_next[pool_prev[d]] = cur;
          give_node(d);
        end
      end
      CMD_INSERT_AFTER, CMD_INSERT_BEFORE: begin
        if (cur != NIL) begin
          n = take_node();
          if (n == NIL) begin
            r.error = 1'b1;
          end else begin
            pool_value[n] = v;
            list_len++;
            if (c == CMD_INSERT_AFTER) begin
              pool_next[n] = pool_next[cur];
              pool_prev[n] = cur;
              pool_next[cur] = n;
              if (cur == tail_idx) tail_idx = n;
              else pool_prev[pool_next[n]] = n;
            end else begin
              pool_prev[n] = pool_prev[cur];
              pool_next[n] = cur;
              pool_prev[cur] = n;
              if (cur == head_idx) head_idx = n;
              else pool_next[pool_prev[n]] = n;
            end
          end
        end
      end
      CMD_GET_CURSOR: begin
        if (cur == NIL) r.error = 1'b1;
        else r.read_value = pool_value[cur];
      end
      CMD_SET_CURSOR: begin
        if (cur != NIL) pool_value[cur] = v;
      end
      CMD_CURSOR_NEXT: begin
        if (cur != NIL) cursor_idx = (cur == tail_idx) ? NIL : pool_next[cur];
      end
      CMD_CURSOR_PREV: begin
        if (cur != NIL) cursor_idx = (cur == head_idx) ? NIL : pool_prev[cur];
      end
      default: ;
    endcase
    r.cursor_valid = (cursor_idx != NIL);
    r.list_empty = (head_idx == NIL);
    return r;
  endfunction

  // idle gap: hold start low, its length set by n
  task automatic idle_for(input int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // present one command beat and wait for it to be taken
  task automatic send_beat(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    value_in <= v;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(list_step_outcome(c, v));
    if (gaps_on && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 11));
  endtask

  // stop driving and wait for every expected beat
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return {1'b1, {(DATA_W-1){1'b0}}};
    if (roll < 16) return {1'b0, {(DATA_W-1){1'b1}}};
    if (roll < 20) return '0;
    if (roll < 24) return '1;
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_insert();
    case ($urandom_range(0, 3))
      0: return CMD_INSERT_FIRST;
      1: return CMD_INSERT_LAST;
      2: return CMD_INSERT_AFTER;
      default: return CMD_INSERT_BEFORE;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input traffic_t mode);
    int unsigned      roll;
    logic [CMD_W-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 2)
      c = CMD_W'($urandom_range(CMD_CURSOR_PREV + 1, CMD_TOP));
    else if (roll < 4)
      c = CMD_DISPOSE;
    else if ((mode == TR_GROW && roll < 55) || (mode == TR_MIXED && roll < 22))
      c = pick_insert();
    else if (mode == TR_SHRINK && roll < 50)
      c = CMD_W'($urandom_range(CMD_DELETE_FIRST, CMD_DELETE_BEFORE));
    else
      c = CMD_W'($urandom_range(CMD_CURSOR_FIRST, CMD_CURSOR_PREV));
    // park the cursor on the list so cursor commands mostly do real work
    if (c >= CMD_DELETE_AFTER && c <= CMD_CURSOR_PREV && cursor_idx == NIL
        && $urandom_range(0, 3) != 0)
      c = ($urandom_range(0, 1) != 0) ? CMD_CURSOR_FIRST : CMD_CURSOR_LAST;
    return c;
  endfunction

  // result beat checker
  always @(posedge clk) begin : check_beat
    outcome_t got;
    outcome_t want;
    if (!rst && done) begin
      got = '0;
      got.read_value = read_value;
      got.error = error;
      got.cursor_valid = cursor_valid;
      got.list_empty = list_empty;
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: value %0d error %0b cursor %0b empty %0b",
                   got.read_value, got.error, got.cursor_valid, got.list_empty);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.read_value !== want.read_value || got.error !== want.error ||
            got.cursor_valid !== want.cursor_valid || got.list_empty !== want.list_empty) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("cmd %0d: expected value %0d error %0b cursor %0b empty %0b, %s",
                     want.op, want.read_value, want.error, want.cursor_valid,
                     want.list_empty,
                     $sformatf("got value %0d error %0b cursor %0b empty %0b",
                               got.read_value, got.error, got.cursor_valid,
                               got.list_empty));
        end
      end
    end
  end

  // empty-list errors, ends of the list, cursor falling off, unused codes
  task automatic test_directed();
    send_beat(CMD_GET_FIRST, '0);
    send_beat(CMD_GET_LAST, '0);
    send_beat(CMD_GET_CURSOR, '0);
    send_beat(CMD_CURSOR_FIRST, '0);
    send_beat(CMD_DELETE_LAST, '0);
    send_beat(CMD_DISPOSE, '0);
    send_beat(CMD_INSERT_AFTER, 32'sd5);
    send_beat(CMD_SET_CURSOR, 32'sd5);
    send_beat(CMD_INSERT_FIRST, 32'sh7fff_ffff);
    send_beat(CMD_INSERT_LAST, 32'sh8000_0000);
    send_beat(CMD_CURSOR_FIRST, '0);
    send_beat(CMD_CURSOR_PREV, '0);
    send_beat(CMD_CURSOR_LAST, '0);
    send_beat(CMD_DELETE_AFTER, '0);
    send_beat(CMD_INSERT_BEFORE, -32'sd1);
    send_beat(CMD_INSERT_AFTER, 32'sd1);
    send_beat(CMD_DELETE_BEFORE, '0);
    send_beat(CMD_SET_CURSOR, 32'sh5a5a_a5a5);
    send_beat(CMD_GET_CURSOR, '0);
    send_beat(CMD_CURSOR_NEXT, '0);
    send_beat(CMD_CURSOR_NEXT, '0);
    send_beat(CMD_CURSOR_FIRST, '0);
    send_beat(CMD_DELETE_BEFORE, '0);
    send_beat(CMD_DELETE_FIRST, '0);
    send_beat(CMD_CURSOR_PREV + 1'b1, 32'sh7fff_ffff);
    send_beat(CMD_TOP, '1);
    send_beat(CMD_DISPOSE, '0);
    drain();
  endtask

  // grow until the pool is exhausted, then insert into a full pool and reuse it
  task automatic test_fill_pool();
    logic [CMD_W-1:0] c;
    while (list_len < NODES) begin
      c = pick_insert();
      if ($urandom_range(0, 7) == 0)
        c = ($urandom_range(0, 1) != 0) ? CMD_CURSOR_NEXT : CMD_CURSOR_PREV;
      if (c != CMD_INSERT_FIRST && c != CMD_INSERT_LAST && cursor_idx == NIL)
        c = CMD_CURSOR_LAST;
      send_beat(c, pick_value());
    end
    send_beat(CMD_CURSOR_FIRST, '0);
    send_beat(CMD_INSERT_FIRST, pick_value());
    send_beat(CMD_INSERT_LAST, pick_value());
    send_beat(CMD_INSERT_AFTER, pick_value());
    send_beat(CMD_INSERT_BEFORE, pick_value());
    send_beat(CMD_GET_LAST, '0);
    send_beat(CMD_DELETE_AFTER, '0);
    send_beat(CMD_INSERT_LAST, pick_value());
    send_beat(CMD_INSERT_FIRST, pick_value());
    send_beat(CMD_DISPOSE, '0);
    repeat (12) send_beat(pick_insert(), pick_value());
    send_beat(CMD_GET_FIRST, '0);
    drain();
  endtask

  // mixed traffic in blocks that lean toward growing, shrinking or neither
  task automatic test_random_traffic();
    traffic_t mode;
    mode = TR_MIXED;
    for (int i = 0; i < 160; i++) begin
      if (i % 40 == 0) begin
        mode = traffic_t'($urandom_range(0, 2));
        gaps_on = (i < 120) && ($urandom_range(0, 2) != 0);
      end
      send_beat(pick_command(mode), pick_value());
    end
    drain();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_pool();
    test_random_traffic();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
hdl/dllc_pkg.sv
hdl/dllc_ram.sv
hdl/doubly_linked_list_cursor_engine_unit.sv
bench/testbench.sv
